>>> rtl/sorted_list_insert_and_dump_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted record store.
// Both macros expect signals named clock and reset in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_AND_DUMP_MACROS_SVH
`define SORTED_LIST_INSERT_AND_DUMP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLI_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted list check failed");

// Next-cycle implication, checked outside reset.
`define SLI_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted list check failed");

`endif

>>> rtl/sli_pkg.sv
// ---------------------------------------------------------------------------
// sli_pkg
// Shared constants and types of the sorted record store.
// ---------------------------------------------------------------------------
package sli_pkg;

   // Number of cells, one record each.
   localparam int DEPTH  = 64;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int KEY_W  = 56;

   // Item kinds.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DUMP   = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic {
      S_IDLE = 1'b0,
      S_DUMP = 1'b1
   } state_type;

   // One stored record.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             gender;
      logic [4:0]       day;
      logic [3:0]       month;
      logic [13:0]      year;
      logic [31:0]      payload;
   } rec_type;

   // Commands broadcast to every cell.
   typedef struct packed {
      logic    ins_en;
      logic    rot_en;
      rec_type new_rec;
   } chain_ctl_type;

endpackage

>>> rtl/sli_cell.sv
// ---------------------------------------------------------------------------
// sli_cell
// One slot of the sorted chain: holds a record and a valid bit, and either
// keeps it, takes the new record, or takes a neighbor's record.
// ---------------------------------------------------------------------------
module sli_cell
   import sli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  chain_ctl_type ctl,
   input  logic          is_first,
   input  rec_type       left_rec,
   input  logic          left_valid,
   input  logic          left_g,
   input  rec_type       right_rec,
   input  logic          right_valid,
   input  rec_type       head_rec,
   output rec_type       rec_q,
   output logic          valid_q,
   output logic          g_out
);

   rec_type rec_ff, rec_in;
   logic    valid_ff, valid_in;
   logic    key_after;

   // The head only yields to a strictly smaller key; other cells yield on ties.
   always_comb begin
      if (is_first) begin
         key_after = rec_ff.key > ctl.new_rec.key;
      end else begin
         key_after = rec_ff.key >= ctl.new_rec.key;
      end
      g_out = !valid_ff || key_after;
   end

   // Next-content selection.
   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (ctl.ins_en) begin
         if (left_g) begin
            rec_in   = left_rec;
            valid_in = left_valid;
         end else if (g_out) begin
            rec_in   = ctl.new_rec;
            valid_in = 1'b1;
         end
      end else if (ctl.rot_en && valid_ff) begin
         // The head record wraps around to the tail of the occupied run.
         if (right_valid) begin
            rec_in = right_rec;
         end else begin
            rec_in = head_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rec_q   = rec_ff;
   assign valid_q = valid_ff;

endmodule

>>> rtl/sli_chain.sv
// ---------------------------------------------------------------------------
// sli_chain
// Row of DEPTH cells kept in ascending key order. An insert shifts the
// cells past the insertion point one place right; a rotate step moves the
// occupied run one place left so that each record passes the head in turn.
// ---------------------------------------------------------------------------
module sli_chain
   import sli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  chain_ctl_type ctl,
   output rec_type       head_rec,
   output logic          full
);

   rec_type rec_q    [DEPTH];
   logic    valid_q  [DEPTH];
   logic    g_q      [DEPTH];
   rec_type left_rec [DEPTH];
   logic    left_val [DEPTH];
   logic    left_g   [DEPTH];
   rec_type right_rec[DEPTH];
   logic    right_val[DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      // Neighbor wiring at both ends of the row.
      if (i == 0) begin : g_left_end
         assign left_rec[i] = ctl.new_rec;
         assign left_val[i] = 1'b0;
         assign left_g[i]   = 1'b0;
      end else begin : g_left
         assign left_rec[i] = rec_q[i-1];
         assign left_val[i] = valid_q[i-1];
         assign left_g[i]   = g_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_right_end
         assign right_rec[i] = rec_q[i];
         assign right_val[i] = 1'b0;
      end else begin : g_right
         assign right_rec[i] = rec_q[i+1];
         assign right_val[i] = valid_q[i+1];
      end

      sli_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .is_first    ((i == 0) ? 1'b1 : 1'b0),
         .left_rec    (left_rec[i]),
         .left_valid  (left_val[i]),
         .left_g      (left_g[i]),
         .right_rec   (right_rec[i]),
         .right_valid (right_val[i]),
         .head_rec    (rec_q[0]),
         .rec_q       (rec_q[i]),
         .valid_q     (valid_q[i]),
         .g_out       (g_q[i])
      );
   end

   assign head_rec = rec_q[0];
   assign full     = valid_q[DEPTH-1];

endmodule

>>> rtl/sorted_list_insert_and_dump.sv
// ---------------------------------------------------------------------------
// sorted_list_insert_and_dump
// Record store kept in ascending key order, with insert and dump items.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one item per beat: an insert (kind 0) with a
//   key and record fields, or a dump (kind 1). The rsp_ channel returns
//   result beats; rsp_last marks the final beat caused by an item.
//   An insert gives one beat with status ok, or full when all DEPTH cells
//   are occupied (record dropped). A dump gives one beat per stored
//   record in key order, one per cycle unless rsp_ready stalls it, and
//   holds the block until its last beat; an empty store gives a single
//   beat with status empty. Every result appears in the cycle after the
//   cycle that produced it, from a registered output stage.
//   The next item is taken once the previous one has finished; an insert
//   may be followed by another item in the very next cycle.
//   A stalled rsp_ready holds the output beat and freezes the dump walk.
//   Reset empties the store and clears any pending result.
// ---------------------------------------------------------------------------
module sorted_list_insert_and_dump
   import sli_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [KEY_W-1:0]      req_key,
   input  logic                  req_gender,
   input  logic [4:0]            req_birth_day,
   input  logic [3:0]            req_birth_month,
   input  logic [13:0]           req_birth_year,
   input  logic [31:0]           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [KEY_W-1:0]      rsp_out_key,
   output logic                  rsp_out_gender,
   output logic [4:0]            rsp_out_day,
   output logic [3:0]            rsp_out_month,
   output logic [13:0]           rsp_out_year,
   output logic [31:0]           rsp_out_payload,
   output logic                  rsp_last
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] dump_cnt_ff, dump_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   rec_type          rec_ff, rec_in;
   logic             last_ff, last_in;
   logic             out_free;
   logic             dump_last;
   chain_ctl_type    ctl;
   rec_type          head_rec;
   logic             full;

   sli_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .head_rec (head_rec),
      .full     (full)
   );

   // The output register can take a new beat when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dump_last = dump_cnt_ff == (count_ff - CNT_W'(1));

   // Next state and control.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_cnt_in  = dump_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      rec_in       = rec_ff;
      last_in      = last_ff;
      req_ready    = 1'b0;

      ctl.ins_en          = 1'b0;
      ctl.rot_en          = 1'b0;
      ctl.new_rec.key     = req_key;
      ctl.new_rec.gender  = req_gender;
      ctl.new_rec.day     = req_birth_day;
      ctl.new_rec.month   = req_birth_month;
      ctl.new_rec.year    = req_birth_year;
      ctl.new_rec.payload = req_payload;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               if (req_kind == KIND_INSERT) begin
                  rsp_valid_in = 1'b1;
                  rec_in       = '0;
                  last_in      = 1'b1;
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in  = ST_OK;
                     ctl.ins_en = 1'b1;
                     count_in   = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rec_in       = '0;
                  last_in      = 1'b1;
                  status_in    = ST_EMPTY;
               end else begin
                  state_in    = S_DUMP;
                  dump_cnt_in = '0;
               end
            end
         end
         S_DUMP: begin
            // Emit the head and rotate the occupied run by one place.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               rec_in       = head_rec;
               last_in      = dump_last;
               ctl.rot_en   = 1'b1;
               dump_cnt_in  = dump_cnt_ff + CNT_W'(1);
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_cnt_ff  <= dump_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rec_ff    <= rec_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_key     = rec_ff.key;
   assign rsp_out_gender  = rec_ff.gender;
   assign rsp_out_day     = rec_ff.day;
   assign rsp_out_month   = rec_ff.month;
   assign rsp_out_year    = rec_ff.year;
   assign rsp_out_payload = rec_ff.payload;
   assign rsp_last        = last_ff;

endmodule

>>> rtl/sli_checker.sv
// ---------------------------------------------------------------------------
// sli_checker
// Port-level checks of the sorted record store, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_list_insert_and_dump_macros.svh"

module sli_checker
   import sli_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_kind,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       rsp_status,
   input logic [KEY_W-1:0] rsp_out_key,
   input logic             rsp_last
);

   logic ins_accept;
   logic err_beat;

   // An insert beat taken by the block, and a result beat that is not ok.
   assign ins_accept = req_valid && req_ready && (req_kind == KIND_INSERT);
   assign err_beat   = rsp_valid && (rsp_status != ST_OK);

   // A stalled result beat stays offered.
   `SLI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // An accepted insert answers with a single final beat in the next cycle.
   `SLI_ASSERT_NEXT(a_ins_rsp, ins_accept, rsp_valid && rsp_last)

   // Full and empty beats are always final and carry no record.
   `SLI_ASSERT_IMPL(a_status_final, err_beat, rsp_last && rsp_out_key == '0)

   // A new item is only taken while the output stage can move.
   `SLI_ASSERT_IMPL(a_ready_free, req_ready && rsp_valid, rsp_ready)

endmodule

bind sorted_list_insert_and_dump sli_checker u_sli_checker (.*);

>>> tb/sorted_list_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sorted_list_checker
// Watches both channels of the sorted record store. It keeps its own ordered
// copy of the stored records and predicts the result beats of every accepted
// item. It compares each result beat with the oldest prediction and counts
// the mismatches for the testbench top.
// ---------------------------------------------------------------------------
module sorted_list_checker
   import sli_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_kind,
   input  logic [KEY_W-1:0] req_key,
   input  logic             req_gender,
   input  logic [4:0]       req_birth_day,
   input  logic [3:0]       req_birth_month,
   input  logic [13:0]      req_birth_year,
   input  logic [31:0]      req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [1:0]       rsp_status,
   input  logic [KEY_W-1:0] rsp_out_key,
   input  logic             rsp_out_gender,
   input  logic [4:0]       rsp_out_day,
   input  logic [3:0]       rsp_out_month,
   input  logic [13:0]      rsp_out_year,
   input  logic [31:0]      rsp_out_payload,
   input  logic             rsp_last,
   output int               fail_count,
   output int               pending
);

   // One predicted result beat.
   typedef struct packed {
      logic [1:0] status;
      rec_type    rec;
      logic       last;
   } beat_type;

   // Records in ascending key order, as the store should hold them.
   rec_type  ordered_records[$];
   // Result beats still to come, oldest first.
   beat_type expected_beats[$];

   // Print one line per mismatch (only the first few) and count it.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < 40)
         $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // Apply one accepted item to the ordered copy and queue its result beats.
   task automatic predict_beats(input logic kind, input rec_type rec);
      beat_type b;
      int       pos;
      b = '0;
      if (kind == KIND_INSERT) begin
         b.last = 1'b1;
         if (ordered_records.size() >= DEPTH) begin
            b.status = ST_FULL;
         end else begin
            // A key equal to the head's goes after the head; otherwise the
            // record goes ahead of the first later entry whose key is not smaller.
            if (ordered_records.size() == 0 || ordered_records[0].key > rec.key) begin
               pos = 0;
            end else begin
               pos = 1;
               while (pos < ordered_records.size() && ordered_records[pos].key < rec.key)
                  pos++;
            end
            ordered_records.insert(pos, rec);
            b.status = ST_OK;
         end
         expected_beats.push_back(b);
      end else if (ordered_records.size() == 0) begin
         b.status = ST_EMPTY;
         b.last   = 1'b1;
         expected_beats.push_back(b);
      end else begin
         for (pos = 0; pos < ordered_records.size(); pos++) begin
            b.status = ST_OK;
            b.rec    = ordered_records[pos];
            b.last   = (pos == ordered_records.size() - 1);
            expected_beats.push_back(b);
         end
      end
   endtask

   // Compare one accepted result beat with the oldest prediction.
   task automatic check_beat();
      beat_type b;
      if (expected_beats.size() == 0) begin
         report_mismatch("unexpected result beat, key", 64'(rsp_out_key), 64'd0);
      end else begin
         b = expected_beats.pop_front();
         if (rsp_status !== b.status)
            report_mismatch("status", 64'(rsp_status), 64'(b.status));
         if (rsp_out_key !== b.rec.key)
            report_mismatch("out_key", 64'(rsp_out_key), 64'(b.rec.key));
         if (rsp_out_gender !== b.rec.gender)
            report_mismatch("out_gender", 64'(rsp_out_gender), 64'(b.rec.gender));
         if (rsp_out_day !== b.rec.day)
            report_mismatch("out_day", 64'(rsp_out_day), 64'(b.rec.day));
         if (rsp_out_month !== b.rec.month)
            report_mismatch("out_month", 64'(rsp_out_month), 64'(b.rec.month));
         if (rsp_out_year !== b.rec.year)
            report_mismatch("out_year", 64'(rsp_out_year), 64'(b.rec.year));
         if (rsp_out_payload !== b.rec.payload)
            report_mismatch("out_payload", 64'(rsp_out_payload), 64'(b.rec.payload));
         if (rsp_last !== b.last)
            report_mismatch("last", 64'(rsp_last), 64'(b.last));
      end
   endtask

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      rec_type rec;
      if (!reset) begin
         if (req_valid && req_ready) begin
            rec.key     = req_key;
            rec.gender  = req_gender;
            rec.day     = req_birth_day;
            rec.month   = req_birth_month;
            rec.year    = req_birth_year;
            rec.payload = req_payload;
            predict_beats(req_kind, rec);
         end
         if (rsp_valid && rsp_ready)
            check_beat();
      end
      pending = expected_beats.size();
   end

endmodule

>>> tb/tb_sorted_list_insert_and_dump.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sorted_list_insert_and_dump
// Testbench of the sorted record store. A directed part covers the empty
// dump, extreme keys and fields, equal keys at the head and further down,
// and keys with bytes after a zero byte. A random part fills the store past
// full with inserts and dumps, under random gaps on both channels, a long
// result stall and a drain pause. The checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_sorted_list_insert_and_dump;
   import sli_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_kind;
   logic [KEY_W-1:0] req_key;
   logic             req_gender;
   logic [4:0]       req_birth_day;
   logic [3:0]       req_birth_month;
   logic [13:0]      req_birth_year;
   logic [31:0]      req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [1:0]       rsp_status;
   logic [KEY_W-1:0] rsp_out_key;
   logic             rsp_out_gender;
   logic [4:0]       rsp_out_day;
   logic [3:0]       rsp_out_month;
   logic [13:0]      rsp_out_year;
   logic [31:0]      rsp_out_payload;
   logic             rsp_last;

   int fail_count;
   int pending;
   int cycle_count = 0;
   bit no_gaps     = 1'b0;
   bit hold_rsp    = 1'b0;

   sorted_list_insert_and_dump u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .req_gender      (req_gender),
      .req_birth_day   (req_birth_day),
      .req_birth_month (req_birth_month),
      .req_birth_year  (req_birth_year),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_gender  (rsp_out_gender),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_out_payload (rsp_out_payload),
      .rsp_last        (rsp_last)
   );

   sorted_list_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .req_gender      (req_gender),
      .req_birth_day   (req_birth_day),
      .req_birth_month (req_birth_month),
      .req_birth_year  (req_birth_year),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_gender  (rsp_out_gender),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_out_payload (rsp_out_payload),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up after a generous number of cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sorted_list_insert_and_dump] ERROR");
         $finish;
      end
   end

   // Idle cycles ahead of one beat, on either side.
   function automatic int draw_gap();
      if (no_gaps)
         return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic rec_type make_rec(input logic [KEY_W-1:0] key, input logic gender,
                                        input logic [4:0] day, input logic [3:0] month,
                                        input logic [13:0] year, input logic [31:0] payload);
      rec_type r;
      r.key     = key;
      r.gender  = gender;
      r.day     = day;
      r.month   = month;
      r.year    = year;
      r.payload = payload;
      return r;
   endfunction

   // Keys: full random, a small pool for repeats, short ID strings, keys
   // with a zero byte in the middle, and tiny values.
   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      int               len;
      int               b;
      k = KEY_W'({$urandom, $urandom});
      case ($urandom_range(0, 4))
         0: ;
         1: begin
            case ($urandom_range(0, 5))
               0: k = '0;
               1: k = {KEY_W{1'b1}};
               2: k = 56'h41_4243_0000_0000;
               3: k = 56'h5A_0000_0000_0000;
               4: k = 56'h30_3031_0000_0000;
               default: k = 56'h41_0041_0000_0000;
            endcase
         end
         2: begin
            len = $urandom_range(1, 7);
            for (b = 0; b < 7; b++)
               k = {k[47:0], (b < len) ? 8'($urandom_range(48, 90)) : 8'h00};
         end
         3: k[8 * $urandom_range(1, 5) +: 8] = 8'h00;
         default: k = KEY_W'($urandom_range(0, 15));
      endcase
      return k;
   endfunction

   function automatic rec_type random_rec();
      return make_rec(random_key(), 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                      4'($urandom_range(0, 12)), 14'($urandom_range(0, 9999)), $urandom);
   endfunction

   // Offer one item and hold it until the block takes the beat.
   task automatic send_item(input logic kind, input rec_type rec);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind        = kind;
      req_key         = rec.key;
      req_gender      = rec.gender;
      req_birth_day   = rec.day;
      req_birth_month = rec.month;
      req_birth_year  = rec.year;
      req_payload     = rec.payload;
      req_valid       = 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Mostly inserts with random content, with a dump now and then.
   task automatic random_item();
      if ($urandom_range(0, 6) == 0)
         send_item(KIND_DUMP, random_rec());
      else
         send_item(KIND_INSERT, random_rec());
   endtask

   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
   endtask

   // Result side: random gaps per beat, and one long counted stall on request.
   initial begin
      int n;
      bit stall_done;
      stall_done = 1'b0;
      rsp_ready  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp && !stall_done) begin
            rsp_ready = 1'b0;
            for (n = 0; n < 300; n++) @(negedge clock);
            stall_done = 1'b1;
         end
         n = draw_gap();
         if (n > 0) begin
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      int i;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_INSERT;
      req_key         = '0;
      req_gender      = 1'b0;
      req_birth_day   = '0;
      req_birth_month = '0;
      req_birth_year  = '0;
      req_payload     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty dump, extremes, equal keys, zero bytes inside keys.
      send_item(KIND_DUMP, make_rec('0, 1'b0, '0, '0, '0, '0));
      send_item(KIND_INSERT, make_rec(56'h41_0000_0000_0000, 1'b0, 5'd0, 4'd0, 14'd0, 32'd0));
      send_item(KIND_INSERT, make_rec({KEY_W{1'b1}}, 1'b1, 5'd31, 4'd12, 14'd9999,
                                      32'hFFFF_FFFF));
      send_item(KIND_INSERT, make_rec('0, 1'b1, 5'd1, 4'd1, 14'd1, 32'h0000_0001));
      send_item(KIND_INSERT, make_rec('0, 1'b0, 5'd2, 4'd2, 14'd2, 32'h0000_0002));
      send_item(KIND_INSERT, make_rec(56'h41_0000_0000_0000, 1'b1, 5'd16, 4'd8, 14'd8192,
                                      32'h8000_0000));
      send_item(KIND_INSERT, make_rec(56'h41_0041_0000_0000, 1'b0, 5'd15, 4'd7, 14'd4095,
                                      32'h7FFF_FFFF));
      send_item(KIND_INSERT, make_rec(56'h41_4100_0000_0000, 1'b1, 5'd10, 4'd5, 14'd1999,
                                      32'hA5A5_5A5A));
      send_item(KIND_DUMP, random_rec());
      send_item(KIND_INSERT, make_rec({KEY_W{1'b1}}, 1'b0, 5'd31, 4'd12, 14'd9999,
                                      32'h1234_5678));
      send_item(KIND_INSERT, make_rec(56'h00_0000_0000_0001, 1'b1, 5'd31, 4'd12, 14'd9999,
                                      32'hFFFF_FFFF));
      send_item(KIND_INSERT, make_rec('0, 1'b1, 5'd5, 4'd3, 14'd5000, 32'h0BAD_F00D));
      send_item(KIND_DUMP, random_rec());
      req_valid = 1'b0;

      // Sender pauses until every result beat has come back.
      wait_drained();

      for (i = 0; i < 90; i++)
         random_item();

      // Long result stall while items keep coming back to back.
      hold_rsp = 1'b1;
      no_gaps  = 1'b1;
      for (i = 0; i < 12; i++)
         random_item();
      no_gaps = 1'b0;

      // More random items, with one stretch free of idle cycles.
      for (i = 0; i < 110; i++) begin
         no_gaps = (i >= 40 && i < 60);
         random_item();
      end
      no_gaps = 1'b0;

      // The store is full by now: one dropped insert and a full dump.
      send_item(KIND_INSERT, random_rec());
      send_item(KIND_DUMP, random_rec());
      req_valid = 1'b0;

      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("[sorted_list_insert_and_dump] OK");
      else
         $display("[sorted_list_insert_and_dump] ERROR");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sli_chain.sv
rtl/sorted_list_insert_and_dump.sv
rtl/sli_checker.sv
tb/sorted_list_checker.sv
tb/tb_sorted_list_insert_and_dump.sv
